// ----- hdl/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the per-address traffic counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned LANES             = 8;
  localparam int unsigned LANE_W            = $clog2(LANES);
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned LEN_W             = 18;
  localparam int unsigned IDX_W             = 8;
  localparam int unsigned CTR_W             = 32;
  localparam int unsigned USED_W            = 9;

  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] destination_address;
    logic [LEN_W-1:0]  packet_length;
    logic [IDX_W-1:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic              slot_valid;
    logic [ADDR_W-1:0] slot_address;
    logic [CTR_W-1:0]  sent_packets;
    logic [CTR_W-1:0]  received_packets;
    logic [CTR_W-1:0]  sent_bytes;
    logic [CTR_W-1:0]  received_bytes;
    logic              table_full;
    logic [USED_W-1:0] entries_used;
  } out_t;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } merge_t;

  // one counter memory word
  typedef struct packed {
    logic [CTR_W-1:0] sp;
    logic [CTR_W-1:0] rp;
    logic [CTR_W-1:0] sb;
    logic [CTR_W-1:0] rb;
  } ctr_t;

endpackage

`default_nettype wire

// ----- hdl/ptc_in_if.sv -----
// ----------------------------------------------------------------------------
// ptc_in_if
// Request channel: valid/ready with one request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_in_if;
  logic          valid;
  logic          ready;
  ptc_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ptc_out_if.sv -----
// ----------------------------------------------------------------------------
// ptc_out_if
// Result channel: valid/ready with one result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_out_if;
  logic          valid;
  logic          ready;
  ptc_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ptc_lane.sv -----
// ----------------------------------------------------------------------------
// ptc_lane
// One search lane: a bank of address keys with registered read and a
// key compare on the row just read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_lane #(
  parameter int unsigned ROWS    = 32,
  parameter int unsigned ROW_W   = 5,
  parameter int unsigned CNT_W   = 9,
  parameter int unsigned LANE_ID = 0
) (
  input  wire logic                      clk_i,
  input  wire logic [ROW_W-1:0]          rd_row_i,
  input  wire logic                      wr_en_i,
  input  wire logic [ROW_W-1:0]          wr_row_i,
  input  wire logic [ptc_pkg::ADDR_W-1:0] wr_key_i,
  input  wire logic [ptc_pkg::ADDR_W-1:0] ref_key_i,
  input  wire logic [CNT_W-1:0]          used_i,
  output logic                           hit_o,
  output logic [ptc_pkg::ADDR_W-1:0]     key_o
);
  import ptc_pkg::*;

  logic [ADDR_W-1:0]       mem [ROWS];
  logic [ADDR_W-1:0]       key_q;
  logic [ROW_W-1:0]        row_q;
  logic [ROW_W+LANE_W-1:0] slot;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_key_i;
    end
    key_q <= mem[rd_row_i];
    row_q <= rd_row_i;
  end

  // only slots below the fill count hold a key
  assign slot  = {row_q, LANE_W'(LANE_ID)};
  assign hit_o = (key_q == ref_key_i) && (32'(slot) < 32'(used_i));
  assign key_o = key_q;

endmodule

`default_nettype wire

// ----- hdl/ptc_merge.sv -----
// ----------------------------------------------------------------------------
// ptc_merge
// Combines the lane hits of one row into a hit flag and the lane number.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_merge (
  input  wire logic [ptc_pkg::LANES-1:0] hit_i,
  output ptc_pkg::merge_t                res_o
);
  import ptc_pkg::*;

  always_comb begin
    res_o = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hit_i[l]) begin
        res_o.hit  = 1'b1;
        res_o.lane = LANE_W'(l);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/per_address_traffic_counter_core.sv -----
// ----------------------------------------------------------------------------
// per_address_traffic_counter_core
// Table of IPv4 addresses with sent/received packet and byte counters.
// ----------------------------------------------------------------------------
// A count request looks up the source and then the destination address; each
// lookup scans the key table one row per cycle with eight lanes side by side,
// followed by a drain step, a decide step and the counter read-modify-write.
// A read request reads the key and counters of its slot directly; the next
// request is taken in the cycle after the result is loaded. Requests are
// handled one at a time; a finished result waits in the output register. An
// address that finds no free slot is not counted and raises table_full.
// Slots fill in allocation order and are never freed.
// ----------------------------------------------------------------------------
`default_nettype none

module per_address_traffic_counter_core #(
  parameter int unsigned TABLE_ENTRIES = ptc_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptc_in_if.sink    in_i,
  ptc_out_if.source out_o
);
  import ptc_pkg::*;

  localparam int unsigned ROWS   = (TABLE_ENTRIES + LANES - 1) / LANES;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD1    = 4'd1;
  localparam logic [3:0] ST_RD2    = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_DRAIN  = 4'd4;
  localparam logic [3:0] ST_DECIDE = 4'd5;
  localparam logic [3:0] ST_CRD    = 4'd6;
  localparam logic [3:0] ST_CUPD   = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  cmp_row_q;
  logic              cmp_vld_q;
  logic              found_q, found_d;
  logic [SLOT_W-1:0] found_slot_q, found_slot_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              alloc_q, alloc_d;
  logic              phase_q, phase_d;
  logic              full_q, full_d;
  logic              full_skip_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              out_vld_q, out_vld_d;
  out_t              out_q, out_d;
  out_t              res_q, res_d;
  in_t               req_q, req_d;
  logic [ADDR_W-1:0] key_q, key_d;

  logic [SLOT_W-1:0] idx_slot;
  logic [ROW_W-1:0]  rd_row;
  logic [LANES-1:0]  hits;
  logic [LANES-1:0]  wr_en;
  logic [ADDR_W-1:0] lane_key [LANES];
  merge_t            mg;
  logic              room;

  ctr_t              ctr_mem [TABLE_ENTRIES];
  ctr_t              ctr_rd_q;
  ctr_t              ctr_cur, ctr_wdata;
  logic              ctr_we;
  logic [SLOT_W-1:0] ctr_addr;

  assign idx_slot = SLOT_W'(req_q.slot_index);
  assign rd_row   = (state_q == ST_RD1) ? ROW_W'(idx_slot >> LANE_W) : row_q;
  assign room     = 32'(used_q) < 32'(TABLE_ENTRIES);

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign wr_en[l] = (state_q == ST_DECIDE) && !found_q && room &&
                      (LANE_W'(used_q) == LANE_W'(l));
    ptc_lane #(
      .ROWS    (ROWS),
      .ROW_W   (ROW_W),
      .CNT_W   (CNT_W),
      .LANE_ID (l)
    ) u_lane (
      .clk_i     (clk_i),
      .rd_row_i  (rd_row),
      .wr_en_i   (wr_en[l]),
      .wr_row_i  (ROW_W'(used_q >> LANE_W)),
      .wr_key_i  (key_q),
      .ref_key_i (key_q),
      .used_i    (used_q),
      .hit_o     (hits[l]),
      .key_o     (lane_key[l])
    );
  end

  ptc_merge u_merge (
    .hit_i (hits),
    .res_o (mg)
  );

  // counter memory, read-modify-write: the word is read in CRD and written in CUPD
  // a full table skips the counter write: CUPD is reached with no slot
  // chosen, so hold the write off through the full flag of this phase
  assign ctr_addr = (state_q == ST_RD1) ? idx_slot : slot_q;
  assign ctr_we   = (state_q == ST_CUPD) && !full_skip_q;

  always_comb begin
    ctr_cur   = alloc_q ? '0 : ctr_rd_q;
    ctr_wdata = ctr_cur;
    if (!phase_q) begin
      ctr_wdata.sp = ctr_cur.sp + CTR_W'(1);
      ctr_wdata.sb = ctr_cur.sb + CTR_W'(req_q.packet_length);
    end else begin
      ctr_wdata.rp = ctr_cur.rp + CTR_W'(1);
      ctr_wdata.rb = ctr_cur.rb + CTR_W'(req_q.packet_length);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctr_we) begin
      ctr_mem[slot_q] <= ctr_wdata;
    end
    ctr_rd_q <= ctr_mem[ctr_addr];
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    found_d      = found_q;
    found_slot_d = found_slot_q;
    slot_d       = slot_q;
    alloc_d      = alloc_q;
    phase_d      = phase_q;
    full_d       = full_q;
    used_d       = used_q;
    out_vld_d    = out_vld_q;
    out_d        = out_q;
    res_d        = res_q;
    req_d        = req_q;
    key_d        = key_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    if (cmp_vld_q && mg.hit && !found_q) begin
      found_d      = 1'b1;
      found_slot_d = SLOT_W'({cmp_row_q, mg.lane});
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          req_d   = in_i.data;
          res_d   = '0;
          key_d   = in_i.data.source_address;
          row_d   = '0;
          found_d = 1'b0;
          phase_d = 1'b0;
          full_d  = 1'b0;
          state_d = (in_i.data.func == FUNC_READ) ? ST_RD1 : ST_SCAN;
        end
      end
      ST_RD1: state_d = ST_RD2;
      ST_RD2: begin
        if (32'(req_q.slot_index) < 32'(used_q)) begin
          res_d.slot_valid       = 1'b1;
          res_d.slot_address     = lane_key[LANE_W'(idx_slot)];
          res_d.sent_packets     = ctr_rd_q.sp;
          res_d.received_packets = ctr_rd_q.rp;
          res_d.sent_bytes       = ctr_rd_q.sb;
          res_d.received_bytes   = ctr_rd_q.rb;
        end
        state_d = ST_FIN;
      end
      ST_SCAN: begin
        if (32'(row_q) == 32'(ROWS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      ST_DRAIN: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (found_q) begin
          slot_d  = found_slot_q;
          alloc_d = 1'b0;
          state_d = ST_CRD;
        end else if (room) begin
          slot_d  = SLOT_W'(used_q);
          alloc_d = 1'b1;
          used_d  = used_q + CNT_W'(1);
          state_d = ST_CRD;
        end else begin
          full_d = 1'b1;
          state_d = ST_CUPD;
        end
      end
      ST_CRD: state_d = ST_CUPD;
      ST_CUPD: begin
        if (!phase_q) begin
          phase_d = 1'b1;
          key_d   = req_q.destination_address;
          row_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_d              = res_q;
          out_d.table_full   = full_q;
          out_d.entries_used = USED_W'(used_q);
          out_vld_d          = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      phase_q   <= 1'b0;
      full_q    <= 1'b0;
      full_skip_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      found_q   <= found_d;
      phase_q   <= phase_d;
      full_q    <= full_d;
      full_skip_q <= (state_q == ST_DECIDE) && !found_q && !room;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    cmp_row_q    <= row_q;
    found_slot_q <= found_slot_d;
    slot_q       <= slot_d;
    alloc_q      <= (state_q == ST_DECIDE) ? alloc_d : alloc_q;
    out_q        <= out_d;
    res_q        <= res_d;
    req_q        <= req_d;
    key_q        <= key_d;
  end

endmodule

`default_nettype wire

// ----- dv/tb_per_address_traffic_counter_core.sv -----
// ----------------------------------------------------------------------------
// tb_per_address_traffic_counter_core
// Self-checking bench for the per-address traffic counter.
// Count and read requests go in from a queue. Each accepted request is run
// through a local copy of the address table to build the result it should
// give. Results are compared field by field, in order. Both sides idle at
// random, and there is one long output hold-off and two full drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_per_address_traffic_counter_core;
  import ptc_pkg::*;

  localparam int unsigned NUM_SLOTS  = TABLE_ENTRIES_DEF;
  localparam int unsigned NUM_RANDOM = 1930;
  localparam int unsigned POOL_SIZE  = 24;

  typedef struct {
    in_t req;
    bit  drain;  // hold this request back until no result is outstanding
  } pending_t;

  logic clk_i;
  logic rst_ni;

  ptc_in_if  req_if ();
  ptc_out_if rsp_if ();

  per_address_traffic_counter_core #(
    .TABLE_ENTRIES (NUM_SLOTS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  pending_t          pending_q[$];
  out_t              slot_reports_q[$];
  logic [ADDR_W-1:0] addr_pool[POOL_SIZE];
  int unsigned       n_accepted;
  int unsigned       fail_count;
  int unsigned       req_gap;
  int unsigned       rsp_stall;
  int unsigned       hold_left;
  bit                hold_done;

  // local copy of the table
  logic [ADDR_W-1:0] tbl_key[NUM_SLOTS];
  bit                tbl_used[NUM_SLOTS];
  logic [CTR_W-1:0]  tbl_sp[NUM_SLOTS];
  logic [CTR_W-1:0]  tbl_rp[NUM_SLOTS];
  logic [CTR_W-1:0]  tbl_sb[NUM_SLOTS];
  logic [CTR_W-1:0]  tbl_rb[NUM_SLOTS];
  int unsigned       tbl_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // -1 when the address is not in the table and the table has no room left
  function automatic int lookup_or_alloc(logic [ADDR_W-1:0] addr);
    int i;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_used[i] && tbl_key[i] == addr) return i;
    end
    if (tbl_count >= NUM_SLOTS) return -1;
    i = tbl_count;
    tbl_key[i]  = addr;
    tbl_used[i] = 1'b1;
    tbl_sp[i]   = '0;
    tbl_rp[i]   = '0;
    tbl_sb[i]   = '0;
    tbl_rb[i]   = '0;
    tbl_count++;
    return i;
  endfunction

  function automatic out_t tally_request(in_t r);
    out_t res;
    int   s;
    int   d;
    res = '0;
    if (r.func == FUNC_COUNT) begin
      s = lookup_or_alloc(r.source_address);
      if (s >= 0) begin
        tbl_sp[s] = tbl_sp[s] + 1;
        tbl_sb[s] = tbl_sb[s] + r.packet_length;
      end else begin
        res.table_full = 1'b1;
      end
      d = lookup_or_alloc(r.destination_address);
      if (d >= 0) begin
        tbl_rp[d] = tbl_rp[d] + 1;
        tbl_rb[d] = tbl_rb[d] + r.packet_length;
      end else begin
        res.table_full = 1'b1;
      end
    end else if (r.slot_index < NUM_SLOTS && tbl_used[r.slot_index]) begin
      res.slot_valid       = 1'b1;
      res.slot_address     = tbl_key[r.slot_index];
      res.sent_packets     = tbl_sp[r.slot_index];
      res.received_packets = tbl_rp[r.slot_index];
      res.sent_bytes       = tbl_sb[r.slot_index];
      res.received_bytes   = tbl_rb[r.slot_index];
    end
    res.entries_used = tbl_count[USED_W-1:0];
    return res;
  endfunction

  // mostly short gaps, a few long ones; none in every third stretch of 250 accepted requests
  function automatic int unsigned pick_gap();
    int unsigned r;
    if ((n_accepted / 250) % 3 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  task automatic add_req(logic fn, logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                         logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx, bit drain);
    pending_t p;
    p.req.func                = fn;
    p.req.source_address      = src;
    p.req.destination_address = dst;
    p.req.packet_length       = len;
    p.req.slot_index          = idx;
    p.drain                   = drain;
    pending_q.push_back(p);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      req_gap      <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        slot_reports_q.push_back(tally_request(req_if.data));
        n_accepted++;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (req_gap > 0) begin
          req_gap      <= req_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && slot_reports_q.size() > 0)) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_q[0].req;
          void'(pending_q.pop_front());
          req_gap      <= pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long output hold-off, so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= 300) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall    <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (slot_reports_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, rsp_if.data);
          fail_count++;
        end else begin
          out_t e;
          e = slot_reports_q.pop_front();
          check_field("slot_valid", e.slot_valid, rsp_if.data.slot_valid);
          check_field("slot_address", e.slot_address, rsp_if.data.slot_address);
          check_field("sent_packets", e.sent_packets, rsp_if.data.sent_packets);
          check_field("received_packets", e.received_packets,
                      rsp_if.data.received_packets);
          check_field("sent_bytes", e.sent_bytes, rsp_if.data.sent_bytes);
          check_field("received_bytes", e.received_bytes, rsp_if.data.received_bytes);
          check_field("table_full", e.table_full, rsp_if.data.table_full);
          check_field("entries_used", e.entries_used, rsp_if.data.entries_used);
        end
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall    <= rsp_stall - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        rsp_stall    <= pick_gap();
      end
    end
  end

  initial begin
    int i;
    logic fn;
    n_accepted = 0;
    fail_count = 0;
    tbl_count  = 0;
    for (i = 0; i < NUM_SLOTS; i++) tbl_used[i] = 1'b0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom();

    // reads of an empty table, then field extremes
    add_req(FUNC_READ, $urandom(), $urandom(), LEN_W'($urandom()), 8'd0, 1'b0);
    add_req(FUNC_READ, $urandom(), $urandom(), LEN_W'($urandom()), 8'd255, 1'b0);
    add_req(FUNC_COUNT, 32'h0, 32'hFFFF_FFFF, 18'h3FFFF, 8'd0, 1'b0);
    add_req(FUNC_COUNT, 32'hFFFF_FFFF, 32'h0, 18'h0, 8'd255, 1'b0);
    add_req(FUNC_COUNT, 32'hC0A8_0001, 32'hC0A8_0001, 18'd1500, 8'd0, 1'b0); // self
    add_req(FUNC_COUNT, 32'h0A00_0001, 32'hC0A8_0001, 18'h3FFFF, 8'hAA, 1'b0);
    add_req(FUNC_COUNT, 32'h0, 32'h0, 18'd64, 8'h55, 1'b0);
    for (i = 0; i < 5; i++) begin
      add_req(FUNC_READ, $urandom(), $urandom(), LEN_W'($urandom()), IDX_W'(i), 1'b0);
    end
    add_req(FUNC_READ, '0, '0, '0, 8'd5, 1'b0);
    add_req(FUNC_READ, '1, '1, '1, 8'd128, 1'b0);

    for (i = 0; i < NUM_RANDOM; i++) begin
      fn = ($urandom_range(0, 9) < 3) ? FUNC_READ : FUNC_COUNT;
      add_req(fn, pick_addr(), pick_addr(),
              ($urandom_range(0, 9) == 0) ? 18'h3FFFF : LEN_W'($urandom()),
              IDX_W'($urandom()), (i == 0 || i == 1000));
    end

    wait (pending_q.size() == 0);
    do @(posedge clk_i); while (req_if.valid || slot_reports_q.size() > 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ptc_pkg.sv
hdl/ptc_in_if.sv
hdl/ptc_out_if.sv
hdl/ptc_lane.sv
hdl/ptc_merge.sv
hdl/per_address_traffic_counter_core.sv
dv/tb_per_address_traffic_counter_core.sv
